@@ sv/inu_pkg.sv @@
// ---------------------------------------------------------------------------
// inu_pkg
// Types and constants shared by the nearest-neighbor upscaler modules.
// ---------------------------------------------------------------------------
package inu_pkg;

	localparam int PIX_W    = 24;
	localparam int SCALE_W  = 6;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 16;
	localparam int PASS_W   = 5;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 2'd2;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] pixel;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic [1:0]       pad_bytes;
		logic             row_last;
		logic             frame_last;
		logic             run_last;
		logic             error;
	} out_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [SCALE_W-1:0] last_idx;
		logic               row_end;
		logic               frame_end;
		logic [1:0]         pad;
		logic               error;
	} cmd_t;

endpackage

@@ sv/integer_nearest_neighbor_upscaler_core.sv @@
// ---------------------------------------------------------------------------
// integer_nearest_neighbor_upscaler_core
// Nearest-neighbor integer upscaler for a 24-bit pixel stream, with a line
// buffer that replays each source row on tick items.
//
//   Channel   Signals                        Carries
//   src       src_valid/src_ready/src_item   pixel or replay tick
//   dst       dst_valid/dst_ready/dst_item   output pixel with row flags
//   cfg       cfg_we/cfg_index/cfg_data      scale, in_width, in_height
//
// Each pixel or replay tick yields scale output pixels, an error item one
// and a tick outside replay none, at one per cycle while dst is not stalled.
// Items pass through the front-end stage register and the command queue
// into the registered output stage.
// The front end keeps accepting while its stage register or the two-entry
// queue has room.
// Reset is asynchronous and clears all control state; the line buffer
// is not cleared.
// ---------------------------------------------------------------------------
module integer_nearest_neighbor_upscaler_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [inu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [inu_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  inu_pkg::in_t                  src_item,
	output logic                          dst_valid,
	input  logic                          dst_ready,
	output inu_pkg::out_t                 dst_item
);

	import inu_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t push_cmd;
	cmd_t head;

	inu_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item (src_item),
		.q_full   (full),
		.push     (push),
		.cmd      (push_cmd)
	);

	inu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (full),
		.empty   (empty),
		.head    (head)
	);

	inu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_item (dst_item)
	);

endmodule

@@ sv/inu_ram.sv @@
// ---------------------------------------------------------------------------
// inu_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module inu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/inu_front.sv @@
// ---------------------------------------------------------------------------
// inu_front
// Accepts input transfers, keeps the row and replay state and the line
// buffer, and turns each item but a tick outside replay into one run command.
// ---------------------------------------------------------------------------
module inu_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [inu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [inu_pkg::CFG_W-1:0]     cfg_data,
	input  logic                     src_valid,
	output logic                     src_ready,
	input  inu_pkg::in_t             src_item,
	input  logic                     q_full,
	output logic                     push,
	output inu_pkg::cmd_t            cmd
);

	import inu_pkg::*;

	localparam int CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1) > WIDTH_W ? $clog2(MAX_WIDTH + 1) : WIDTH_W;
	localparam logic [WW-1:0]      W_MAX = WW'(MAX_WIDTH);
	localparam logic [SCALE_W-1:0] S_MAX = SCALE_W'(MAX_SCALE);

	logic [SCALE_W-1:0]  scale_q;
	logic [WIDTH_W-1:0]  in_width_q;
	logic [HEIGHT_W-1:0] in_height_q;

	logic [CW-1:0]       column_q;
	logic [PASS_W-1:0]   pass_q;
	logic                replaying_q;
	logic [HEIGHT_W-1:0] row_count_q;

	logic       s1_valid_q;
	cmd_t       cmd_s1;
	logic       use_ram_s1;

	logic [SCALE_W-1:0]  s_eff;
	logic [WW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [1:0]          pad;
	logic                accept;
	logic                is_px;
	logic                err;
	logic                drop;
	logic                row_end;
	logic [PASS_W-1:0]   pass_n;
	logic                rp_end;
	logic                fin_row;
	logic                fend;
	logic [PIX_W-1:0]    rdata;

	always_comb begin
		if (scale_q == '0) begin
			s_eff = SCALE_W'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			s_eff = S_MAX;
		end else begin
			s_eff = scale_q;
		end
		if (in_width_q == '0) begin
			w_eff = WW'(1);
		end else if (WW'(in_width_q) > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = WW'(in_width_q);
		end
		h_eff = (in_height_q == '0) ? HEIGHT_W'(1) : in_height_q;
	end

	assign pad = 2'(2'd0 - 2'(w_eff[1:0] * s_eff[1:0] * 2'd3));

	assign push      = s1_valid_q && !q_full;
	assign src_ready = !s1_valid_q || !q_full;
	assign accept    = src_valid && src_ready;

	assign is_px   = (src_item.action == ACT_PIXEL);
	assign err     = is_px && replaying_q;
	assign drop    = !is_px && !replaying_q;
	assign row_end = (WW'(column_q) + WW'(1)) >= w_eff;
	assign pass_n  = pass_q + PASS_W'(1);
	assign rp_end  = (pass_n == '0) || ((SCALE_W'(pass_n) + SCALE_W'(1)) >= s_eff);
	assign fin_row = row_end && ((is_px && s_eff == SCALE_W'(1)) || (!is_px && rp_end));
	assign fend    = (17'(row_count_q) + 17'd1) >= 17'(h_eff);

	inu_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (accept && is_px && !replaying_q),
		.waddr(column_q),
		.wdata(src_item.pixel),
		.re   (accept && !is_px && replaying_q),
		.raddr(column_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_W'(1);
			in_width_q  <= WIDTH_W'(1);
			in_height_q <= HEIGHT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				CFG_IN_WIDTH:  in_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IN_HEIGHT: in_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			pass_q      <= '0;
			replaying_q <= 1'b0;
			row_count_q <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= !drop;
			end else if (push) begin
				s1_valid_q <= 1'b0;
			end
			if (accept && !err && !drop) begin
				if (row_end) begin
					column_q <= '0;
				end else begin
					column_q <= column_q + CW'(1);
				end
				if (is_px && row_end && s_eff != SCALE_W'(1)) begin
					replaying_q <= 1'b1;
					pass_q      <= '0;
				end
				if (!is_px && row_end) begin
					if (rp_end) begin
						replaying_q <= 1'b0;
						pass_q      <= '0;
					end else begin
						pass_q <= pass_n;
					end
				end
				if (fin_row) begin
					row_count_q <= fend ? '0 : row_count_q + HEIGHT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_ram_s1         <= !is_px;
			cmd_s1.pixel       <= err ? '0 : src_item.pixel;
			cmd_s1.last_idx    <= err ? '0 : s_eff - SCALE_W'(1);
			cmd_s1.row_end     <= !err && row_end;
			cmd_s1.frame_end   <= !err && fin_row && fend;
			cmd_s1.pad         <= (!err && row_end) ? pad : 2'd0;
			cmd_s1.error       <= err;
		end
	end

	always_comb begin
		cmd = cmd_s1;
		if (use_ram_s1) begin
			cmd.pixel = rdata;
		end
	end

endmodule

@@ sv/inu_queue.sv @@
// ---------------------------------------------------------------------------
// inu_queue
// Two-entry command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module inu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  inu_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output inu_pkg::cmd_t head
);

	import inu_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ sv/inu_back.sv @@
// ---------------------------------------------------------------------------
// inu_back
// Expands each run command into its output pixels, one per cycle while the
// queue is not empty and the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module inu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  inu_pkg::cmd_t head,
	output logic          pop,
	output logic          dst_valid,
	input  logic          dst_ready,
	output inu_pkg::out_t dst_item
);

	import inu_pkg::*;

	logic [SCALE_W-1:0] k_q;
	logic               dst_valid_q;
	out_t               dst_item_q;
	logic               load;
	logic               last;

	assign load = !empty && (!dst_valid_q || dst_ready);
	assign last = (k_q == head.last_idx);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q         <= last ? '0 : k_q + SCALE_W'(1);
				dst_valid_q <= 1'b1;
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dst_item_q.out_pixel  <= head.pixel;
			dst_item_q.pad_bytes  <= last ? head.pad : 2'd0;
			dst_item_q.row_last   <= last && head.row_end;
			dst_item_q.frame_last <= last && head.frame_end;
			dst_item_q.run_last   <= last;
			dst_item_q.error      <= head.error;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

endmodule

@@ sv/inu_checker.sv @@
// ---------------------------------------------------------------------------
// inu_checker
// Port-level checks on the upscaler result stream.
// ---------------------------------------------------------------------------
module inu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          dst_valid,
	input logic          dst_ready,
	input inu_pkg::out_t dst_item
);

	import inu_pkg::*;

	// A result that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("result withdrawn before transfer");

	// An error result is a single result that closes its run, with every other field zero.
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.error |-> dst_item.run_last && !dst_item.row_last &&
		!dst_item.frame_last && dst_item.pad_bytes == 2'd0 && dst_item.out_pixel == '0)
		else $error("malformed error result");

	// Padding only follows the last pixel of a row.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.pad_bytes != 2'd0 |-> dst_item.row_last)
		else $error("padding outside row end");

	// The frame ends only on a row end that also closes a run.
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.frame_last |-> dst_item.row_last && dst_item.run_last)
		else $error("frame end without row end");

endmodule

bind integer_nearest_neighbor_upscaler_core inu_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.dst_valid(dst_valid),
	.dst_ready(dst_ready),
	.dst_item (dst_item)
);
